// ----- rtl/afda_pkg.sv -----
package afda_pkg;

  localparam int CORDIC_STEPS = 31;
  localparam int AXIS_SLOT    = 21;
  localparam int AXIS_FRAC    = 19;
  localparam int CW           = 34;
  localparam int REG_BITS     = 63;

  localparam logic [31:0] QUARTER_TURN  = 32'h4000_0000;
  localparam logic [31:0] HALF_TURN     = 32'h8000_0000;
  localparam logic [31:0] THREE_QUARTER = 32'hC000_0000;
  localparam logic signed [CW-1:0] CORDIC_INV_GAIN = 34'sd652032874;

  typedef enum logic [1:0] {
    REG_POS = 2'd0,
    REG_AX  = 2'd1,
    REG_AY  = 2'd2,
    REG_AZ  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    VEC_RUN     = 2'd0,
    VEC_ZERO    = 2'd1,
    VEC_FIXED   = 2'd2
  } vec_mode_t;

  function automatic logic [31:0] atan_val(input int i);
    logic [31:0] t [CORDIC_STEPS];
    t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
          32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
          32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
          32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
          32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
          32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
          32'h00000001};
    return t[i];
  endfunction

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [31:0]          a;
  } cordic_t;

endpackage

// ----- rtl/antenna_frame_direction_angles_unit.sv -----
// pipeline from input request to result: front end, square
// root, vectoring and rotation cordic chains of 31 cells each, back end
// throughput: one request per cycle; the whole pipeline advances when the
// output register is free or being taken
// reset: synchronous active-low rst_n clears valids and position and loads the default axes
module antenna_frame_direction_angles_unit #(
  parameter int COORD_BITS     = 21,
  parameter int ANGLE_BITS     = 16,
  parameter int UNIT_FRAC_BITS = 14
) (
  input  logic clk,
  input  logic rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // point_x, point_y, point_z
  input  logic [((3*COORD_BITS+7)/8)*8-1:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // polar_angle, azimuth, theta_hat_x/y/z, phi_hat_x/y/z
  output logic [((2*ANGLE_BITS+6*(UNIT_FRAC_BITS+2)+7)/8)*8-1:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import afda_pkg::*;

  localparam int UW  = UNIT_FRAC_BITS + 2;
  localparam int OW  = ((2*ANGLE_BITS+6*UW+7)/8)*8;
  localparam int LAT = 4 + 1 + 31 + 31 + 1 + 31 + 3;
  localparam int TH_SH = 32 - ANGLE_BITS;
  localparam logic signed [63:0] LIM = 64'sd1 <<< UNIT_FRAC_BITS;

  logic [62:0] pos_r, ax_r, ay_r, az_r;
  logic        en;
  logic [LAT-1:0] vld_r;
  logic        out_valid_r;
  logic [OW-1:0] out_data_r;

  assign en         = ~out_valid_r | out_tready;
  assign in_tready  = en;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ax_r  <= 63'd2305843009213693952;
      ay_r  <= 63'd1099511627776;
      az_r  <= 63'd524288;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_POS: pos_r <= cfg_data[62:0];
        REG_AX:  ax_r  <= cfg_data[62:0];
        REG_AY:  ay_r  <= cfg_data[62:0];
        REG_AZ:  az_r  <= cfg_data[62:0];
        default: ;
      endcase
    end
  end

  function automatic logic signed [20:0] sl(input logic [62:0] r, input int k);
    return r[AXIS_SLOT*(2-k) +: AXIS_SLOT];
  endfunction

  // stage 1: difference vector
  logic signed [COORD_BITS:0] d_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        d_r[k] <= $signed({pos_r[COORD_BITS*(2-k)+COORD_BITS-1],
                           pos_r[COORD_BITS*(2-k) +: COORD_BITS]})
                - $signed({in_tdata[COORD_BITS*k+COORD_BITS-1],
                           in_tdata[COORD_BITS*k +: COORD_BITS]});
      end
    end
  end

  // stage 2: products, stage 3: projections
  logic signed [43:0] m_r [3][3];
  logic signed [45:0] pr_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        m_r[0][j] <= sl(ax_r, j) * d_r[j];
        m_r[1][j] <= sl(ay_r, j) * d_r[j];
        m_r[2][j] <= sl(az_r, j) * d_r[j];
      end
      for (int k = 0; k < 3; k++) begin
        pr_r[k] <= 46'(m_r[k][0]) + 46'(m_r[k][1]) + 46'(m_r[k][2]);
      end
    end
  end

  // scale: smallest shift bringing all magnitudes below 2^30
  logic [45:0] mag [3];
  logic [45:0] mx;
  logic [4:0]  sh;
  logic signed [31:0] sc [3];
  always_comb begin
    mx = '0;
    for (int k = 0; k < 3; k++) begin
      mag[k] = pr_r[k][45] ? 46'(-pr_r[k]) : 46'(pr_r[k]);
      mx = mx | mag[k];
    end
    sh = '0;
    for (int b = 30; b < 46; b++) begin
      if (mx[b]) sh = 5'(b - 29);
    end
    for (int k = 0; k < 3; k++) begin
      sc[k] = pr_r[k][45] ? -$signed(32'(mag[k] >> sh)) : $signed(32'(mag[k] >> sh));
    end
  end

  logic signed [31:0] xs_r, ys_r, zs_r;
  logic [61:0] sq_r;
  always_ff @(posedge clk) begin
    if (en) begin
      xs_r <= sc[0];
      ys_r <= sc[1];
      zs_r <= sc[2];
    end
  end
  logic [61:0] xx, yy;
  assign xx = 62'($signed(xs_r) * $signed(xs_r));
  assign yy = 62'($signed(ys_r) * $signed(ys_r));
  always_ff @(posedge clk) begin
    if (en) sq_r <= xx + yy;
  end

  // carry x,y,z across the square root
  logic signed [31:0] xd_r [32], yd_r [32], zd_r [32];
  always_ff @(posedge clk) begin
    if (en) begin
      xd_r[0] <= xs_r; yd_r[0] <= ys_r; zd_r[0] <= zs_r;
      for (int i = 1; i < 32; i++) begin
        xd_r[i] <= xd_r[i-1]; yd_r[i] <= yd_r[i-1]; zd_r[i] <= zd_r[i-1];
      end
    end
  end

  logic [30:0] rho;
  afda_isqrt u_sqrt (.clk(clk), .en(en), .v_in(sq_r), .r_out(rho));

  // vectoring: theta from (rho, z), phi from (y, x), run side by side
  function automatic cordic_t vec_prep(input logic signed [31:0] y,
                                       input logic signed [31:0] x,
                                       output vec_mode_t md,
                                       output logic [31:0] fix);
    cordic_t c;
    c.x = CW'(x); c.y = CW'(y); c.a = '0;
    md = VEC_RUN; fix = '0;
    if (y == 0) begin
      md = VEC_FIXED; fix = x < 0 ? HALF_TURN : 32'd0;
    end else if (x == 0) begin
      md = VEC_FIXED; fix = y > 0 ? QUARTER_TURN : THREE_QUARTER;
    end else if (x < 0) begin
      c.x = -CW'(x); c.y = -CW'(y); c.a = HALF_TURN;
    end
    return c;
  endfunction

  cordic_t   th_in, ph_in, th_out, ph_out;
  vec_mode_t th_md, ph_md;
  logic [31:0] th_fix, ph_fix;
  logic      xy0;
  always_comb begin
    th_in = vec_prep($signed({1'b0, rho}), zd_r[31], th_md, th_fix);
    if (zd_r[31] == 0) begin
      th_md = VEC_FIXED; th_fix = QUARTER_TURN;
    end
    xy0 = (xd_r[31] == 0) && (yd_r[31] == 0);
    ph_in = vec_prep(yd_r[31], xd_r[31], ph_md, ph_fix);
    if (xy0) begin
      ph_md = VEC_ZERO; ph_fix = THREE_QUARTER;
    end
  end

  logic [65:0] th_side, ph_side;
  afda_chain #(.W(66), .ROT(1'b0)) u_vth (
    .clk(clk), .en(en), .d_in(th_in), .side_in({th_md, th_fix, 32'd0}),
    .d_out(th_out), .side_out(th_side)
  );
  afda_chain #(.W(66), .ROT(1'b0)) u_vph (
    .clk(clk), .en(en), .d_in(ph_in), .side_in({ph_md, ph_fix, 32'd0}),
    .d_out(ph_out), .side_out(ph_side)
  );

  logic [31:0] theta_r, phi_r;
  logic        phz_r;
  always_ff @(posedge clk) begin
    if (en) begin
      theta_r <= vec_mode_t'(th_side[65:64]) == VEC_RUN ? th_out.a : th_side[63:32];
      phi_r   <= vec_mode_t'(ph_side[65:64]) == VEC_RUN ? ph_out.a : ph_side[63:32];
      phz_r   <= vec_mode_t'(ph_side[65:64]) == VEC_ZERO;
    end
  end

  // rotation: sin/cos of theta and phi
  function automatic cordic_t rot_prep(input logic [31:0] a, output logic neg);
    cordic_t c;
    logic signed [32:0] z;
    z = $signed({a[31], a});
    neg = 1'b0;
    if (z > $signed({1'b0, QUARTER_TURN})) begin
      z = z - 33'sh0_8000_0000; neg = 1'b1;
    end else if (z < -$signed({1'b0, QUARTER_TURN})) begin
      z = z + 33'sh0_8000_0000; neg = 1'b1;
    end
    c.x = CORDIC_INV_GAIN; c.y = '0; c.a = z[31:0];
    return c;
  endfunction

  cordic_t rt_in, rp_in, rt_out, rp_out;
  logic    nt, np;
  always_comb begin
    rt_in = rot_prep(theta_r, nt);
    rp_in = rot_prep(phi_r, np);
  end

  logic [66:0] rt_side, rp_side;
  afda_chain #(.W(67), .ROT(1'b1)) u_rth (
    .clk(clk), .en(en), .d_in(rt_in), .side_in({nt, 1'b0, phz_r, theta_r, phi_r}),
    .d_out(rt_out), .side_out(rt_side)
  );
  afda_chain #(.W(67), .ROT(1'b1)) u_rph (
    .clk(clk), .en(en), .d_in(rp_in), .side_in({np, 2'b0, 64'd0}),
    .d_out(rp_out), .side_out(rp_side)
  );

  function automatic logic signed [UW-1:0] fin(input logic signed [CW-1:0] v,
                                               input logic neg);
    logic signed [CW:0] t;
    t = neg ? -$signed({v[CW-1], v}) : $signed({v[CW-1], v});
    t = (t + ($signed({{CW{1'b0}}, 1'b1}) <<< (29 - UNIT_FRAC_BITS)))
        >>> (30 - UNIT_FRAC_BITS);
    if (t > (CW+1)'(LIM)) t = (CW+1)'(LIM);
    if (t < -(CW+1)'(LIM)) t = -(CW+1)'(LIM);
    return t[UW-1:0];
  endfunction

  logic signed [UW-1:0] ct_r, st_r, cp_r, sp_r;
  logic [ANGLE_BITS-1:0] pa_r, az_r1;
  logic [31:0] rt_th, rt_ph;
  assign rt_th = rt_side[63:32];
  assign rt_ph = rt_side[31:0];
  always_ff @(posedge clk) begin
    if (en) begin
      ct_r <= fin(rt_out.x, rt_side[66]);
      st_r <= fin(rt_out.y, rt_side[66]);
      cp_r <= fin(rp_out.x, rp_side[66]);
      sp_r <= fin(rp_out.y, rp_side[66]);
      pa_r <= ANGLE_BITS'((33'(rt_th) + (33'd1 << (TH_SH - 1))) >> TH_SH);
      az_r1 <= rt_side[64] ? '0 :
               ANGLE_BITS'((33'(rt_ph) + (33'd1 << (TH_SH - 1))) >> TH_SH);
    end
  end

  // local unit vectors
  logic signed [2*UW-1:0] tv_r [3];
  logic signed [UW-1:0]   cp2_r, sp2_r;
  logic [ANGLE_BITS-1:0]  pa2_r, az2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      tv_r[0] <= ct_r * cp_r;
      tv_r[1] <= ct_r * sp_r;
      tv_r[2] <= -(2*UW)'(st_r) <<< UNIT_FRAC_BITS;
      cp2_r <= cp_r; sp2_r <= sp_r; pa2_r <= pa_r; az2_r <= az_r1;
    end
  end

  // rotate to global: products then sums
  logic signed [2*UW+AXIS_SLOT-1:0] g_m [3][3];
  logic signed [UW+AXIS_SLOT-1:0]   h_m [3][2];
  logic [ANGLE_BITS-1:0]  pa3_r, az3_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        g_m[j][0] <= tv_r[0] * sl(ax_r, j);
        g_m[j][1] <= tv_r[1] * sl(ay_r, j);
        g_m[j][2] <= tv_r[2] * sl(az_r, j);
        h_m[j][0] <= -(UW+AXIS_SLOT)'(sp2_r) * sl(ax_r, j);
        h_m[j][1] <= cp2_r * sl(ay_r, j);
      end
      pa3_r <= pa2_r; az3_r <= az2_r;
    end
  end

  function automatic logic signed [UW-1:0] rsat(input logic signed [63:0] v, input int s);
    logic signed [63:0] t;
    t = (v + (64'sd1 <<< (s - 1))) >>> s;
    if (t > LIM) t = LIM;
    if (t < -LIM) t = -LIM;
    return t[UW-1:0];
  endfunction

  logic [OW-1:0] res;
  always_comb begin
    res = '0;
    res[ANGLE_BITS-1:0] = pa3_r;
    res[ANGLE_BITS +: ANGLE_BITS] = az3_r;
    for (int j = 0; j < 3; j++) begin
      res[2*ANGLE_BITS + UW*j +: UW] =
        rsat(64'(g_m[j][0]) + 64'(g_m[j][1]) + 64'(g_m[j][2]), UNIT_FRAC_BITS + AXIS_FRAC);
      res[2*ANGLE_BITS + UW*(3+j) +: UW] =
        rsat(64'(h_m[j][0]) + 64'(h_m[j][1]), AXIS_FRAC);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[LAT-2:0], in_tvalid};
      out_valid_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_data_r <= res;
  end
endmodule

// ----- rtl/afda_cell.sv -----
module afda_cell #(
  parameter int STEP = 0
) (
  input  logic                clk,
  input  logic                en,
  input  logic                rot,
  input  afda_pkg::cordic_t   d_in,
  output afda_pkg::cordic_t   d_out
);
  import afda_pkg::*;

  cordic_t d_out_r, d_out_nxt;
  logic signed [CW-1:0] xs, ys;
  logic up;

  always_comb begin
    xs = d_in.x >>> STEP;
    ys = d_in.y >>> STEP;
    up = rot ? ~d_in.a[31] : ~d_in.y[CW-1];
    d_out_nxt = d_in;
    if (rot) begin
      if (up) begin
        d_out_nxt.x = d_in.x - ys;
        d_out_nxt.y = d_in.y + xs;
        d_out_nxt.a = d_in.a - atan_val(STEP);
      end else begin
        d_out_nxt.x = d_in.x + ys;
        d_out_nxt.y = d_in.y - xs;
        d_out_nxt.a = d_in.a + atan_val(STEP);
      end
    end else begin
      if (up) begin
        d_out_nxt.x = d_in.x + ys;
        d_out_nxt.y = d_in.y - xs;
        d_out_nxt.a = d_in.a + atan_val(STEP);
      end else begin
        d_out_nxt.x = d_in.x - ys;
        d_out_nxt.y = d_in.y + xs;
        d_out_nxt.a = d_in.a - atan_val(STEP);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out_r <= d_out_nxt;
    end
  end

  assign d_out = d_out_r;
endmodule

// ----- rtl/afda_chain.sv -----
module afda_chain #(
  parameter int  W    = 16,
  parameter bit  ROT  = 1'b0
) (
  input  logic              clk,
  input  logic              en,
  input  afda_pkg::cordic_t d_in,
  input  logic [W-1:0]      side_in,
  output afda_pkg::cordic_t d_out,
  output logic [W-1:0]      side_out
);
  import afda_pkg::*;

  cordic_t     stg [CORDIC_STEPS+1];
  logic [W-1:0] side_r [CORDIC_STEPS];

  assign stg[0] = d_in;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    afda_cell #(.STEP(i)) u_cell (
      .clk(clk), .en(en), .rot(ROT), .d_in(stg[i]), .d_out(stg[i+1])
    );
    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          side_r[0] <= side_in;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) begin
          side_r[i] <= side_r[i-1];
        end
      end
    end
  end

  assign d_out    = stg[CORDIC_STEPS];
  assign side_out = side_r[CORDIC_STEPS-1];
endmodule

// ----- rtl/afda_isqrt.sv -----
module afda_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [61:0] v_in,
  output logic [30:0] r_out
);
  localparam int STEPS = 31;

  logic [61:0] v_r [STEPS+1];
  logic [61:0] r_r [STEPS+1];

  assign v_r[0] = v_in;
  assign r_r[0] = '0;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic [61:0] BIT = 62'd1 << (2 * (STEPS - 1 - i));
    logic [61:0] v_q, r_q;
    always_ff @(posedge clk) begin
      if (en) begin
        if (v_r[i] >= r_r[i] + BIT) begin
          v_q <= v_r[i] - (r_r[i] + BIT);
          r_q <= (r_r[i] >> 1) + BIT;
        end else begin
          v_q <= v_r[i];
          r_q <= r_r[i] >> 1;
        end
      end
    end
    assign v_r[i+1] = v_q;
    assign r_r[i+1] = r_q;
  end

  assign r_out = r_r[STEPS][30:0];
endmodule

// ----- dv/direction_angle_monitor.sv -----
`timescale 1ns / 1ps
module direction_angle_monitor (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [63:0]  in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [127:0] out_tdata,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  output int           mismatches,
  output int           pending,
  output int           checked
);
  import afda_pkg::*;

  typedef struct packed {
    logic [15:0] polar;
    logic [15:0] azim;
    logic [15:0] thx;
    logic [15:0] thy;
    logic [15:0] thz;
    logic [15:0] phx;
    logic [15:0] phy;
    logic [15:0] phz;
  } angles_t;

  localparam longint UNIT_LIM = 64'sd16384;
  localparam longint GAIN_INV = 64'sd652032874;

  bit [31:0]   turn_tab [0:30];
  logic [62:0] ant_pos, ax_x, ax_y, ax_z;
  angles_t     angle_q [$];

  initial begin
    turn_tab = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
                 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
                 32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
                 32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
                 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
                 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
                 32'h00000001};
    mismatches = 0;
    checked = 0;
    pending = 0;
  end

  function automatic longint slot21(logic [62:0] r, int k);
    logic signed [20:0] t;
    t = r[k*21 +: 21];
    return t;
  endfunction

  function automatic longint round_sh(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v);
    return v > UNIT_LIM ? UNIT_LIM : (v < -UNIT_LIM ? -UNIT_LIM : v);
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic bit [31:0] atan_turns(longint y, longint x);
    bit [31:0] a;
    longint xs, ys;
    a = 0;
    if (y == 0) return x < 0 ? HALF_TURN : 32'h0;
    if (x == 0) return y > 0 ? QUARTER_TURN : THREE_QUARTER;
    if (x < 0) begin
      x = -x;
      y = -y;
      a = HALF_TURN;
    end
    for (int i = 0; i < 31; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; a = a + turn_tab[i];
      end else begin
        x = x - ys; y = y + xs; a = a - turn_tab[i];
      end
    end
    return a;
  endfunction

  task automatic cos_sin(input bit [31:0] a, output longint c, output longint s);
    int     sa;
    longint z, x, y, xs, ys;
    bit     flip;
    sa = a;
    z = sa;
    x = GAIN_INV;
    y = 0;
    flip = 0;
    if (z > 64'sh4000_0000) begin
      z = z - 64'sh8000_0000; flip = 1;
    end else if (z < -64'sh4000_0000) begin
      z = z + 64'sh8000_0000; flip = 1;
    end
    for (int i = 0; i < 31; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - longint'(turn_tab[i]);
      end else begin
        x = x + ys; y = y - xs; z = z + longint'(turn_tab[i]);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = clip(round_sh(x, 16));
    s = clip(round_sh(y, 16));
  endtask

  function automatic longint shrink(longint v, int s);
    longint unsigned m;
    m = v < 0 ? -v : v;
    m = m >> s;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  task automatic predict_angles(input logic [63:0] pt, output angles_t r);
    longint ux[3], uy[3], uz[3], d[3], pr[3];
    longint xs, ys, zs, ct, st, cp, sp, g, h;
    longint tv[3];
    longint unsigned m, a, rho, tt;
    bit [31:0] theta, phi;
    int s;
    for (int k = 0; k < 3; k++) begin
      ux[k] = slot21(ax_x, 2 - k);
      uy[k] = slot21(ax_y, 2 - k);
      uz[k] = slot21(ax_z, 2 - k);
      d[k] = slot21(ant_pos, 2 - k) - slot21(pt[62:0], k);
    end
    pr[0] = ux[0] * d[0] + ux[1] * d[1] + ux[2] * d[2];
    pr[1] = uy[0] * d[0] + uy[1] * d[1] + uy[2] * d[2];
    pr[2] = uz[0] * d[0] + uz[1] * d[1] + uz[2] * d[2];
    m = 0;
    for (int k = 0; k < 3; k++) begin
      a = pr[k] < 0 ? -pr[k] : pr[k];
      if (a > m) m = a;
    end
    s = 0;
    while ((m >> s) >= (64'h1 << 30)) s++;
    xs = shrink(pr[0], s);
    ys = shrink(pr[1], s);
    zs = shrink(pr[2], s);
    rho = floor_root(xs * xs + ys * ys);
    theta = (zs == 0) ? QUARTER_TURN : atan_turns(longint'(rho), zs);
    tt = theta;
    r.polar = (tt + 64'h8000) >> 16;
    if (xs == 0 && ys == 0) begin
      phi = THREE_QUARTER;
      r.azim = 0;
    end else begin
      phi = atan_turns(ys, xs);
      tt = phi;
      r.azim = (tt + 64'h8000) >> 16;
    end
    cos_sin(theta, ct, st);
    cos_sin(phi, cp, sp);
    tv[0] = ct * cp;
    tv[1] = ct * sp;
    tv[2] = -st * UNIT_LIM;
    for (int j = 0; j < 3; j++) begin
      g = clip(round_sh(tv[0] * ux[j] + tv[1] * uy[j] + tv[2] * uz[j], 33));
      h = clip(round_sh(-sp * ux[j] + cp * uy[j], 19));
      case (j)
        0: begin r.thx = g; r.phx = h; end
        1: begin r.thy = g; r.phy = h; end
        default: begin r.thz = g; r.phz = h; end
      endcase
    end
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      if (mismatches < 10)
        $display("[%0t] mismatch %s: expected %0d (0x%h) got %0d (0x%h)", $time, name,
                 $signed(want), want, $signed(got), got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    angles_t want, got;
    if (!rst_n) begin
      ant_pos <= '0;
      ax_x <= 63'h2000_0000_0000_0000;
      ax_y <= 63'h0000_0100_0000_0000;
      ax_z <= 63'h0000_0000_0008_0000;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_POS: ant_pos <= cfg_data[62:0];
          REG_AX:  ax_x <= cfg_data[62:0];
          REG_AY:  ax_y <= cfg_data[62:0];
          REG_AZ:  ax_z <= cfg_data[62:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        predict_angles(in_tdata, want);
        angle_q.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got = {out_tdata[15:0], out_tdata[31:16], out_tdata[47:32], out_tdata[63:48],
               out_tdata[79:64], out_tdata[95:80], out_tdata[111:96], out_tdata[127:112]};
        if (angle_q.size() == 0) begin
          if (mismatches < 10) $display("[%0t] result with no request outstanding", $time);
          mismatches++;
        end else begin
          want = angle_q.pop_front();
          check_field("polar_angle", want.polar, got.polar);
          check_field("azimuth", want.azim, got.azim);
          check_field("theta_hat_x", want.thx, got.thx);
          check_field("theta_hat_y", want.thy, got.thy);
          check_field("theta_hat_z", want.thz, got.thz);
          check_field("phi_hat_x", want.phx, got.phx);
          check_field("phi_hat_y", want.phy, got.phy);
          check_field("phi_hat_z", want.phz, got.phz);
        end
        checked++;
      end
      pending = angle_q.size();
    end
  end

endmodule

// ----- dv/antenna_frame_direction_angles_unit_tb.sv -----
`timescale 1ns / 1ps
module antenna_frame_direction_angles_unit_tb;
  import afda_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int MAXC = 1048575;
  localparam int MINC = -1048576;
  localparam int UNIT = 524288;

  logic         clk, rst_n;
  logic         in_tvalid, in_tready;
  logic [63:0]  in_tdata;
  logic         out_tvalid, out_tready;
  logic [127:0] out_tdata;
  logic         cfg_valid, cfg_ready;
  logic [1:0]   cfg_index;
  logic [63:0]  cfg_data;

  int mismatches, pending, checked;
  int idle_cycles, sent;
  int ant[3];
  bit quiet, hold_req;
  int hold_left;

  antenna_frame_direction_angles_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  direction_angle_monitor mon (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending), .checked(checked)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver side
  initial begin
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= quiet || ($urandom_range(0, 99) >= 19);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("stalled for %0d cycles", idle_cycles);
        $display("antenna_frame_direction_angles_unit_tb: FAIL");
        $finish;
      end
    end
  end

  function automatic logic [63:0] pack3(int x, int y, int z);
    logic [20:0] a, b, c;
    a = x;
    b = y;
    c = z;
    return {1'($urandom_range(0, 1)), a, b, c};
  endfunction

  function automatic int clamp21(int v);
    return v > MAXC ? MAXC : (v < MINC ? MINC : v);
  endfunction

  function automatic int rnd21();
    logic signed [20:0] t;
    t = $urandom;
    return t;
  endfunction

  task automatic send_point(input int x, input int y, input int z);
    logic [20:0] a, b, c;
    a = x;
    b = y;
    c = z;
    if (!quiet)
      while ($urandom_range(0, 99) < 19) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, c, b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_frame(input int px, input int py, input int pz,
                            input logic [63:0] vx, input logic [63:0] vy,
                            input logic [63:0] vz);
    drain();
    write_reg(REG_POS, pack3(px, py, pz));
    write_reg(REG_AX, vx);
    write_reg(REG_AY, vy);
    write_reg(REG_AZ, vz);
    @(negedge clk);
    cfg_valid <= 1'b0;
    ant[0] = px;
    ant[1] = py;
    ant[2] = pz;
  endtask

  task automatic random_points(input int n, input int pause_at);
    int r, k, p[3];
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) drain();
      r = $urandom_range(0, 99);
      for (k = 0; k < 3; k++) p[k] = ant[k];
      if (r < 40) begin
        for (k = 0; k < 3; k++) p[k] = rnd21();
      end else if (r < 60) begin
        for (k = 0; k < 3; k++) p[k] = clamp21(ant[k] + $urandom_range(0, 2000) - 1000);
      end else if (r < 68) begin
        // zero-length vector
      end else if (r < 85) begin
        k = $urandom_range(0, 2);
        p[k] = rnd21();
      end else begin
        for (k = 0; k < 3; k++) p[k] = clamp21(ant[k] + $urandom_range(0, 128) - 64);
      end
      send_point(p[0], p[1], p[2]);
    end
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    out_tready = 0;
    cfg_valid = 0;
    cfg_index = REG_POS;
    cfg_data = '0;
    quiet = 0;
    hold_req = 0;
    idle_cycles = 0;
    sent = 0;
    ant = '{0, 0, 0};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // reset frame: axis points, zero vector, field extremes, zero z
    send_point(0, 0, 0);
    send_point(1, 0, 0);
    send_point(-1, 0, 0);
    send_point(0, 1, 0);
    send_point(0, -1, 0);
    send_point(0, 0, 1);
    send_point(0, 0, -1);
    send_point(MAXC, MAXC, MAXC);
    send_point(MINC, MINC, MINC);
    send_point(MAXC, MINC, 0);
    send_point(MINC, MAXC, MAXC);
    send_point(0, 0, MAXC);
    send_point(0, 0, MINC);
    send_point(5, 7, 0);
    send_point(3, -4, 12);
    send_point(MAXC, 0, MINC);
    send_point(-1, -1, 0);
    random_points(240, -1);

    load_frame(rnd21(), rnd21(), rnd21(),
               pack3(0, UNIT, 0), pack3(0, 0, UNIT), pack3(UNIT, 0, 0));
    random_points(255, 120);

    load_frame(MAXC, MAXC, MAXC,
               pack3(-UNIT, 0, 0), pack3(0, -UNIT, MAXC), pack3(MINC, 0, -UNIT));
    send_point(MINC, MINC, MINC);
    send_point(MAXC, MAXC, MAXC);
    random_points(250, -1);

    load_frame(MINC, MINC, MINC,
               pack3(rnd21(), rnd21(), rnd21()), pack3(rnd21(), rnd21(), rnd21()),
               pack3(rnd21(), rnd21(), rnd21()));
    send_point(MAXC, MAXC, MAXC);
    random_points(250, -1);

    load_frame(rnd21(), rnd21(), rnd21(),
               pack3(370728, 370728, 0), pack3(-370728, 370728, 0), pack3(0, 0, UNIT));
    quiet = 1;
    random_points(255, -1);
    quiet = 0;

    load_frame(rnd21() / 4, rnd21() / 4, rnd21() / 4,
               pack3(UNIT, 0, 0), pack3(0, UNIT, 0), pack3(0, 0, UNIT));
    hold_req = 1;
    random_points(255, -1);

    drain();
    repeat (110) @(posedge clk);
    $display("sent %0d points over six antenna frames, %0d results checked", sent, checked);
    $display("covered zero vectors, on-axis points, coordinate extremes and back-pressure");
    if (mismatches == 0 && pending == 0) begin
      $display("antenna_frame_direction_angles_unit_tb: PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending);
      $display("antenna_frame_direction_angles_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
